// ----- sv/wdt_pkg.sv -----
// ----------------------------------------------------------------------------
// Wake deadline table package
// Shared constants, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package wdt_pkg;

  // Table sizes.
  localparam int SLOT_COUNT    = 8;
  localparam int BLOCKER_COUNT = 8;

  // Index widths into the slot and blocker arrays (at least one bit).
  localparam int SLOT_IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int BLK_IW  = (BLOCKER_COUNT > 1) ? $clog2(BLOCKER_COUNT) : 1;

  // Field widths.
  localparam int FUNC_W   = 3;
  localparam int INDEX_W  = 4;
  localparam int WORD_W   = 32;
  localparam int ACTION_W = 2;
  localparam int DELAY_W  = 42;

  // Constants of the timing arithmetic.
  localparam logic [WORD_W-1:0]  EPOCH_RESET   = 32'd1000000000;
  localparam logic [WORD_W-1:0]  DELAY_CAP     = 32'h7FFF_FFFF;
  localparam logic [DELAY_W-1:0] MS_PER_SECOND = 42'd1000;

  // Operation codes.
  localparam logic [FUNC_W-1:0] FUNC_QUERY     = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_SCHED_EP  = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_SCHED_DLY = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_CANCEL    = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_BLOCKER   = 3'd4;

  // Wake actions.
  localparam logic [ACTION_W-1:0] ACTION_SILENT     = 2'd0;
  localparam logic [ACTION_W-1:0] ACTION_FOREGROUND = 2'd1;

  // Slot kinds.
  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_EPOCH = 2'd1,
    KIND_MONO  = 2'd2
  } kind_t;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_SCAN,
    ST_DRAIN,
    ST_PUBLISH
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;     // latch the accepted input beat
    logic apply;       // apply the table update and clear the scan
    logic scan_en;     // evaluate the slot under the scan pointer
    logic publish;     // load the result register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_last;   // scan pointer is on the last slot
    logic out_busy;    // result register holds a beat that is not taken
  } status_t;

endpackage

// ----- sv/wake_deadline_table_unit.sv -----
// ----------------------------------------------------------------------------
// Wake deadline table unit
// Per-slot wake deadlines and sleep blockers; each beat applies any table update
// and returns the earliest usable wake delay and the sleep permission.
//
//   Channel  Direction  Handshake              Payload
//   in_      input      in_valid / in_ready    func, indexes, request, now
//   out_     output     out_valid / out_ready  plan_found, delay, action, sleep_ok
//   cfg_     input      cfg_valid / cfg_ready  min_trusted_epoch (cfg_data)
//
// A beat passes from acceptance to result through an update state, a scan of
// the slots one at a time through the shared evaluation unit, a drain state that
// folds in the last slot, and a publish state that loads the result register.
// Reset is synchronous and active low; it arms no slot and clears all blockers.
// A stalled result holds in its register; the next input beat is accepted
// meanwhile and waits at publish until that result is taken.
// ----------------------------------------------------------------------------
module wake_deadline_table_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  // Configuration.
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [wdt_pkg::WORD_W-1:0]      cfg_data,
  // Input channel.
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [wdt_pkg::FUNC_W-1:0]      in_func,
  input  logic [wdt_pkg::INDEX_W-1:0]     in_source_index,
  input  logic [wdt_pkg::WORD_W-1:0]      in_epoch_seconds,
  input  logic [wdt_pkg::WORD_W-1:0]      in_delay_request_ms,
  input  logic [wdt_pkg::ACTION_W-1:0]    in_request_action,
  input  logic [wdt_pkg::INDEX_W-1:0]     in_blocker_index,
  input  logic                            in_blocker_active,
  input  logic [wdt_pkg::WORD_W-1:0]      in_now_ms,
  input  logic [wdt_pkg::WORD_W-1:0]      in_wall_secs,
  // Result channel.
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_plan_found,
  output logic [wdt_pkg::DELAY_W-1:0]     out_wake_wait_ms,
  output logic [wdt_pkg::ACTION_W-1:0]    out_wake_action,
  output logic                            out_sleep_ok
);

  wdt_pkg::cmd_t    cmd;
  wdt_pkg::status_t status;
  logic             cfg_wr;

  // The threshold register takes a write in any cycle.
  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  wdt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  wdt_dp u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .status              (status),
    .cfg_wr              (cfg_wr),
    .cfg_data            (cfg_data),
    .in_func             (in_func),
    .in_source_index     (in_source_index),
    .in_epoch_seconds    (in_epoch_seconds),
    .in_delay_request_ms (in_delay_request_ms),
    .in_request_action   (in_request_action),
    .in_blocker_index    (in_blocker_index),
    .in_blocker_active   (in_blocker_active),
    .in_now_ms           (in_now_ms),
    .in_wall_secs        (in_wall_secs),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_plan_found      (out_plan_found),
    .out_wake_wait_ms    (out_wake_wait_ms),
    .out_wake_action     (out_wake_action),
    .out_sleep_ok        (out_sleep_ok)
  );

endmodule

// ----- sv/wdt_ctrl.sv -----
// ----------------------------------------------------------------------------
// Wake deadline table controller
// Sequences capture, update, slot scan and result publish for each beat.
// ----------------------------------------------------------------------------
module wdt_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  wdt_pkg::status_t status,
  output wdt_pkg::cmd_t    cmd
);

  wdt_pkg::state_t state_r;
  wdt_pkg::state_t state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= wdt_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      wdt_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = wdt_pkg::ST_UPDATE;
      end
      wdt_pkg::ST_UPDATE: begin
        state_nxt = wdt_pkg::ST_SCAN;
      end
      wdt_pkg::ST_SCAN: begin
        if (status.scan_last) state_nxt = wdt_pkg::ST_DRAIN;
      end
      wdt_pkg::ST_DRAIN: begin
        state_nxt = wdt_pkg::ST_PUBLISH;
      end
      wdt_pkg::ST_PUBLISH: begin
        if (!status.out_busy) state_nxt = wdt_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = wdt_pkg::ST_IDLE;
      end
    endcase
  end

  // Output decode.
  always_comb begin
    in_ready    = 1'b0;
    cmd         = '0;
    unique case (state_r)
      wdt_pkg::ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      wdt_pkg::ST_UPDATE: begin
        cmd.apply = 1'b1;
      end
      wdt_pkg::ST_SCAN: begin
        cmd.scan_en = 1'b1;
      end
      wdt_pkg::ST_DRAIN: begin
        cmd = '0;
      end
      wdt_pkg::ST_PUBLISH: begin
        cmd.publish = !status.out_busy;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

// ----- sv/wdt_dp.sv -----
// ----------------------------------------------------------------------------
// Wake deadline table datapath
// Slot and blocker storage, threshold register, two-stage slot scan and
// the result register.
// ----------------------------------------------------------------------------
module wdt_dp (
  input  logic                            clk,
  input  logic                            rst_n,
  input  wdt_pkg::cmd_t                   cmd,
  output wdt_pkg::status_t                status,
  // Configuration.
  input  logic                            cfg_wr,
  input  logic [wdt_pkg::WORD_W-1:0]      cfg_data,
  // Input beat.
  input  logic [wdt_pkg::FUNC_W-1:0]      in_func,
  input  logic [wdt_pkg::INDEX_W-1:0]     in_source_index,
  input  logic [wdt_pkg::WORD_W-1:0]      in_epoch_seconds,
  input  logic [wdt_pkg::WORD_W-1:0]      in_delay_request_ms,
  input  logic [wdt_pkg::ACTION_W-1:0]    in_request_action,
  input  logic [wdt_pkg::INDEX_W-1:0]     in_blocker_index,
  input  logic                            in_blocker_active,
  input  logic [wdt_pkg::WORD_W-1:0]      in_now_ms,
  input  logic [wdt_pkg::WORD_W-1:0]      in_wall_secs,
  // Result beat.
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_plan_found,
  output logic [wdt_pkg::DELAY_W-1:0]     out_wake_wait_ms,
  output logic [wdt_pkg::ACTION_W-1:0]    out_wake_action,
  output logic                            out_sleep_ok
);

  localparam int SC = wdt_pkg::SLOT_COUNT;
  localparam int BC = wdt_pkg::BLOCKER_COUNT;
  localparam int SIW = wdt_pkg::SLOT_IW;
  localparam int BIW = wdt_pkg::BLK_IW;

  // Captured input beat.
  logic [wdt_pkg::FUNC_W-1:0]   func_r;
  logic [wdt_pkg::INDEX_W-1:0]  src_r;
  logic [wdt_pkg::WORD_W-1:0]   ep_r;
  logic [wdt_pkg::WORD_W-1:0]   dly_r;
  logic [wdt_pkg::ACTION_W-1:0] act_r;
  logic [wdt_pkg::INDEX_W-1:0]  blk_r;
  logic                         bact_r;
  logic [wdt_pkg::WORD_W-1:0]   now_ms_r;
  logic [wdt_pkg::WORD_W-1:0]   now_ep_r;

  // Threshold register and table storage.
  logic [wdt_pkg::WORD_W-1:0]   min_epoch_r;
  wdt_pkg::kind_t               kind_r   [SC];
  logic [wdt_pkg::WORD_W-1:0]   value_r  [SC];
  logic [wdt_pkg::ACTION_W-1:0] action_r [SC];
  logic [BC-1:0]                blk_flags_r;

  // Scan pointer, stage registers and running best.
  logic [SIW-1:0]               idx_r;
  logic                         stg_v_r;
  logic                         stg_use_r;
  logic [wdt_pkg::DELAY_W-1:0]  stg_d_r;
  logic [wdt_pkg::ACTION_W-1:0] stg_act_r;
  logic                         found_r;
  logic [wdt_pkg::DELAY_W-1:0]  best_r;
  logic [wdt_pkg::ACTION_W-1:0] best_act_r;

  // Result register.
  logic                         out_valid_r;
  logic                         out_found_r;
  logic [wdt_pkg::DELAY_W-1:0]  out_delay_r;
  logic [wdt_pkg::ACTION_W-1:0] out_act_r;
  logic                         out_can_r;

  // Update decode.
  logic                         src_ok;
  logic                         blk_ok;
  logic [SIW-1:0]               src_sel;
  logic [BIW-1:0]               blk_sel;
  logic [wdt_pkg::WORD_W-1:0]   dly_capped;

  // Slot evaluation.
  logic [wdt_pkg::WORD_W-1:0]   ep_diff;
  logic [wdt_pkg::WORD_W-1:0]   ms_diff;
  logic                         eval_use;
  logic [wdt_pkg::DELAY_W-1:0]  eval_d;

  // Capture the accepted beat.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      func_r   <= in_func;
      src_r    <= in_source_index;
      ep_r     <= in_epoch_seconds;
      dly_r    <= in_delay_request_ms;
      act_r    <= in_request_action;
      blk_r    <= in_blocker_index;
      bact_r   <= in_blocker_active;
      now_ms_r <= in_now_ms;
      now_ep_r <= in_wall_secs;
    end
  end

  // Threshold register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_epoch_r <= wdt_pkg::EPOCH_RESET;
    end else if (cfg_wr) begin
      min_epoch_r <= cfg_data;
    end
  end

  // Index range checks and the capped delay.
  always_comb begin
    src_ok     = ({1'b0, src_r} < (wdt_pkg::INDEX_W + 1)'(SC));
    blk_ok     = ({1'b0, blk_r} < (wdt_pkg::INDEX_W + 1)'(BC));
    src_sel    = src_r[SIW-1:0];
    blk_sel    = blk_r[BIW-1:0];
    dly_capped = (dly_r > wdt_pkg::DELAY_CAP) ? wdt_pkg::DELAY_CAP : dly_r;
  end

  // Slot table update.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SC; i++) begin
        kind_r[i]   <= wdt_pkg::KIND_NONE;
        value_r[i]  <= '0;
        action_r[i] <= wdt_pkg::ACTION_SILENT;
      end
    end else if (cmd.apply && src_ok) begin
      case (func_r)
        wdt_pkg::FUNC_SCHED_EP: begin
          if (ep_r != '0) begin
            kind_r[src_sel]   <= wdt_pkg::KIND_EPOCH;
            value_r[src_sel]  <= ep_r;
            action_r[src_sel] <= act_r;
          end
        end
        wdt_pkg::FUNC_SCHED_DLY: begin
          kind_r[src_sel]   <= wdt_pkg::KIND_MONO;
          value_r[src_sel]  <= now_ms_r + dly_capped;
          action_r[src_sel] <= act_r;
        end
        wdt_pkg::FUNC_CANCEL: begin
          kind_r[src_sel]   <= wdt_pkg::KIND_NONE;
          value_r[src_sel]  <= '0;
          action_r[src_sel] <= wdt_pkg::ACTION_SILENT;
        end
        default: begin
          // Queries and blocker writes leave the slots alone.
        end
      endcase
    end
  end

  // Blocker flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blk_flags_r <= '0;
    end else if (cmd.apply && blk_ok && (func_r == wdt_pkg::FUNC_BLOCKER)) begin
      blk_flags_r[blk_sel] <= bact_r;
    end
  end

  // Delay of the slot under the scan pointer.
  always_comb begin
    ep_diff  = value_r[idx_r] - now_ep_r;
    ms_diff  = value_r[idx_r] - now_ms_r;
    eval_use = 1'b0;
    eval_d   = '0;
    case (kind_r[idx_r])
      wdt_pkg::KIND_EPOCH: begin
        eval_use = (now_ep_r >= min_epoch_r);
        if (value_r[idx_r] > now_ep_r) begin
          eval_d = wdt_pkg::DELAY_W'(ep_diff) * wdt_pkg::MS_PER_SECOND;
        end
      end
      wdt_pkg::KIND_MONO: begin
        eval_use = 1'b1;
        if ((ms_diff != '0) && !ms_diff[wdt_pkg::WORD_W-1]) begin
          eval_d = wdt_pkg::DELAY_W'(ms_diff);
        end
      end
      default: begin
        eval_use = 1'b0;
      end
    endcase
  end

  // Scan pointer and the evaluation stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= '0;
      stg_v_r <= 1'b0;
    end else begin
      stg_v_r <= cmd.scan_en;
      if (cmd.apply) begin
        idx_r <= '0;
      end else if (cmd.scan_en && !status.scan_last) begin
        idx_r <= idx_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_en) begin
      stg_use_r <= eval_use;
      stg_d_r   <= eval_d;
      stg_act_r <= action_r[idx_r];
    end
  end

  // Running minimum; foreground wins a tie.
  always_ff @(posedge clk) begin
    if (cmd.apply) begin
      found_r    <= 1'b0;
      best_r     <= '0;
      best_act_r <= wdt_pkg::ACTION_SILENT;
    end else if (stg_v_r && stg_use_r) begin
      if (!found_r || (stg_d_r < best_r)) begin
        found_r    <= 1'b1;
        best_r     <= stg_d_r;
        best_act_r <= stg_act_r;
      end else if ((stg_d_r == best_r) && (stg_act_r == wdt_pkg::ACTION_FOREGROUND)) begin
        best_act_r <= wdt_pkg::ACTION_FOREGROUND;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.publish) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      out_found_r <= found_r;
      out_delay_r <= best_r;
      out_act_r   <= best_act_r;
      out_can_r   <= ~|blk_flags_r;
    end
  end

  // Status and result ports.
  always_comb begin
    status.scan_last = (idx_r == SIW'(SC - 1));
    status.out_busy  = out_valid_r && !out_ready;
    out_valid        = out_valid_r;
    out_plan_found   = out_found_r;
    out_wake_wait_ms = out_delay_r;
    out_wake_action  = out_act_r;
    out_sleep_ok     = out_can_r;
  end

endmodule
